[design/tsm_pkg.sv]
// Package for the TLB slot manager: table geometry, field widths, action codes
// and the command and status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package tsm_pkg;

  localparam int unsigned Slots       = 64;
  localparam int unsigned WiredSlots  = 8;
  localparam int unsigned SlotW       = $clog2(Slots);
  localparam int unsigned CntW        = $clog2(Slots + 1);
  localparam int unsigned ActW        = 2;
  localparam int unsigned PageW       = 20;
  localparam int unsigned FrameW      = 20;
  localparam int unsigned EntryW      = PageW + FrameW;

  typedef enum logic [ActW-1:0] {
    ACT_INSERT    = 2'd0,
    ACT_INV_ALL   = 2'd1,
    ACT_INV_FRAME = 2'd2,
    ACT_RSVD      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic emit;
  } tsm_cmd_t;

  typedef struct packed {
    logic done;
  } tsm_sts_t;

endpackage

`default_nettype wire

[design/tsm_if.sv]
// Request and response channel interfaces of the TLB slot manager.
// Depends on tsm_pkg for the field widths.
`default_nettype none

interface tsm_req_if;
  import tsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [ActW-1:0]   action;
  logic [PageW-1:0]  virt_page;
  logic [FrameW-1:0] phys_frame;

  modport source (output valid, output action, output virt_page, output phys_frame,
                  input ready);
  modport sink   (input valid, input action, input virt_page, input phys_frame,
                  output ready);
endinterface

interface tsm_rsp_if;
  import tsm_pkg::*;

  logic             valid;
  logic             ready;
  logic [SlotW-1:0] slot_written;
  logic             replaced_valid;
  logic [CntW-1:0]  cleared_count;

  modport source (output valid, output slot_written, output replaced_valid,
                  output cleared_count, input ready);
  modport sink   (input valid, input slot_written, input replaced_valid,
                  input cleared_count, output ready);
endinterface

`default_nettype wire

[design/tsm_ctrl.sv]
// Controller of the TLB slot manager: sequences load, slot scan and result
// transfer, and owns the response valid flag. Depends on tsm_pkg.
`default_nettype none

module tsm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      tsm_pkg::tsm_cmd_t cmd_o,
  input  wire tsm_pkg::tsm_sts_t sts_i
);
  import tsm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        // The output register frees up in the same cycle its transfer completes.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SCAN))
    else $error("accepted request did not start a scan");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("result emitted without raising response valid");

  a_valid_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESULT))
    else $error("response valid rose outside the result state");

endmodule

`default_nettype wire

[design/tsm_datapath.sv]
// Datapath of the TLB slot manager: entry memory, valid bits, slot scan
// pipeline, random-slot counter and result registers. Depends on tsm_pkg.
`default_nettype none

module tsm_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire tsm_pkg::tsm_cmd_t         cmd_i,
  output      tsm_pkg::tsm_sts_t         sts_o,
  input  wire logic [tsm_pkg::ActW-1:0]  action_i,
  input  wire logic [tsm_pkg::PageW-1:0] virt_page_i,
  input  wire logic [tsm_pkg::FrameW-1:0] phys_frame_i,
  output      logic [tsm_pkg::SlotW-1:0] slot_written_o,
  output      logic                      replaced_valid_o,
  output      logic [tsm_pkg::CntW-1:0]  cleared_count_o
);
  import tsm_pkg::*;

  localparam logic [SlotW-1:0] TopSlot   = SlotW'(Slots - 1);
  localparam logic [SlotW-1:0] WiredSlot = SlotW'(WiredSlots);

  logic [EntryW-1:0] entry_mem [Slots];

  action_e           act_q;
  logic [PageW-1:0]  page_q;
  logic [FrameW-1:0] frame_q;

  logic [SlotW-1:0]  rd_idx_q, rd_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [SlotW-1:0]  cmp_idx_q;
  logic [FrameW-1:0] rd_frame_q;

  logic [Slots-1:0]  valid_q, valid_d;
  logic [SlotW-1:0]  rand_q, rand_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SlotW-1:0]  res_slot_q, res_slot_d;
  logic              res_repl_q, res_repl_d;

  logic [SlotW-1:0]  out_slot_q;
  logic              out_repl_q;
  logic [CntW-1:0]   out_cnt_q;

  logic              cmp_valid;
  logic              free_hit;
  logic              clr_hit;
  logic              last_slot;
  logic              done;
  logic              wr_en;
  logic [SlotW-1:0]  rand_slot;
  logic [SlotW-1:0]  ins_slot;

  // Compare stage: the slot whose frame was read in the previous cycle.
  always_comb begin
    cmp_valid = valid_q[cmp_idx_q];
    free_hit  = cmp_vld_q && (act_q == ACT_INSERT) && !cmp_valid;
    clr_hit   = cmp_vld_q && cmp_valid &&
                ((act_q == ACT_INV_ALL) ||
                 ((act_q == ACT_INV_FRAME) && (rd_frame_q == frame_q)));
    last_slot = cmp_vld_q && (cmp_idx_q == TopSlot);
    done      = (act_q == ACT_RSVD) || free_hit || last_slot;
    rand_slot = (rand_q > TopSlot) ? TopSlot : rand_q;
    ins_slot  = free_hit ? cmp_idx_q : rand_slot;
    wr_en     = cmd_i.scan && done && (act_q == ACT_INSERT);
  end

  assign sts_o.done = done;

  always_comb begin
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    res_slot_d = res_slot_q;
    res_repl_d = res_repl_q;
    rd_idx_d   = rd_idx_q;
    cmp_vld_d  = cmp_vld_q;
    rand_d     = rand_q;
    if (cmd_i.load) begin
      cnt_d      = '0;
      res_slot_d = '0;
      res_repl_d = 1'b0;
      rd_idx_d   = '0;
      cmp_vld_d  = 1'b0;
    end
    if (cmd_i.scan) begin
      rd_idx_d  = rd_idx_q + 1'b1;
      cmp_vld_d = 1'b1;
      if (clr_hit) begin
        valid_d[cmp_idx_q] = 1'b0;
        cnt_d              = cnt_q + 1'b1;
      end
      if (wr_en) begin
        valid_d[ins_slot] = 1'b1;
        res_slot_d        = ins_slot;
        res_repl_d        = !free_hit;
      end
    end
    // The counter steps once per item, after an insert has used it.
    if (cmd_i.emit) begin
      if ((rand_q <= WiredSlot) || (rand_q > TopSlot)) begin
        rand_d = TopSlot;
      end else begin
        rand_d = rand_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rand_q     <= TopSlot;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      cnt_q      <= '0;
      res_slot_q <= '0;
      res_repl_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      rand_q     <= rand_d;
      rd_idx_q   <= rd_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      cnt_q      <= cnt_d;
      res_slot_q <= res_slot_d;
      res_repl_q <= res_repl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_e'(action_i);
      page_q  <= virt_page_i;
      frame_q <= phys_frame_i;
    end
    cmp_idx_q <= rd_idx_q;
    if (cmd_i.emit) begin
      out_slot_q <= res_slot_q;
      out_repl_q <= res_repl_q;
      out_cnt_q  <= cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[ins_slot] <= {page_q, frame_q};
    end
    rd_frame_q <= entry_mem[rd_idx_q][FrameW-1:0];
  end

  assign slot_written_o   = out_slot_q;
  assign replaced_valid_o = out_repl_q;
  assign cleared_count_o  = out_cnt_q;

  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[res_slot_q])
    else $error("inserted slot is not valid after the write");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Slots))
    else $error("cleared count exceeds the table size");

  a_scan_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && cmp_vld_q) |-> (cmp_idx_q == SlotW'(rd_idx_q - 1'b1)))
    else $error("compare stage is out of step with the read address");

endmodule

`default_nettype wire

[design/tlb_slot_manager.sv]
// Top level of the TLB slot manager: joins the controller and the datapath
// to the request and response channels. Depends on tsm_pkg, tsm_if.
//
//   channel  direction  payload
//   req_i    in         action, virt_page, phys_frame
//   rsp_o    out        slot_written, replaced_valid, cleared_count
//
// One item at a time. After the accepting cycle the slot scan reads one frame
// per cycle through a one-stage memory pipeline, and a result cycle follows.
// Invalidate actions scan every slot before the result is valid, and the next
// request can be taken as soon as the result is valid. Insert stops at the
// first free slot; code 3 ends the scan at once.
// Reset clears all valid bits at once and sets the random slot to the top.
// A stalled response holds the result; a new request is taken meanwhile.
`default_nettype none

module tlb_slot_manager (
  input wire logic clk_i,
  input wire logic rst_ni,
  tsm_req_if.sink   req_i,
  tsm_rsp_if.source rsp_o
);
  import tsm_pkg::*;

  tsm_cmd_t cmd;
  tsm_sts_t sts;

  tsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tsm_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (req_i.action),
    .virt_page_i      (req_i.virt_page),
    .phys_frame_i     (req_i.phys_frame),
    .slot_written_o   (rsp_o.slot_written),
    .replaced_valid_o (rsp_o.replaced_valid),
    .cleared_count_o  (rsp_o.cleared_count)
  );

endmodule

`default_nettype wire

[test/testbench.sv]
// Testbench of the TLB slot manager: a queue-fed request driver and a response
// monitor that checks every transfer against a table model kept in step here.
// Depends on tsm_pkg, tsm_if and the tlb_slot_manager RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tsm_pkg::*;

  localparam int unsigned TotalItems  = 1950;
  localparam int unsigned HoldLen     = 500;
  localparam int unsigned StuckLimit  = 4000;
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned PoolSize    = 8;

  typedef struct packed {
    action_e           action;
    logic [PageW-1:0]  page;
    logic [FrameW-1:0] frame;
  } tlb_req_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             replaced;
    logic [CntW-1:0]  cleared;
  } tlb_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tsm_req_if req_ch();
  tsm_rsp_if rsp_ch();

  tlb_slot_manager DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  always #6 clk_i = ~clk_i;

  // Table model: only frames and valid bits affect any result.
  logic [FrameW-1:0] tbl_frame [Slots];
  logic              tbl_valid [Slots];
  logic [SlotW-1:0]  rnd_slot = SlotW'(Slots - 1);

  tlb_req_t request_q[$];
  tlb_rsp_t slot_result_q[$];

  int items_sent   = 0;
  int results_seen = 0;
  int errors       = 0;
  int hold_cycles  = 0;
  int hold_mark    = -1;
  int stuck_cycles = 0;
  tlb_rsp_t got_rsp;
  tlb_rsp_t want_rsp;

  initial begin
    for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
  end

  function automatic tlb_rsp_t apply_to_table(tlb_req_t rq);
    tlb_rsp_t    r;
    int unsigned n;
    bit          found;
    r = '0;
    n = 0;
    found = 1'b0;
    case (rq.action)
      ACT_INSERT: begin
        for (int i = 0; i < Slots; i++) begin
          if (!found && !tbl_valid[i]) begin
            r.slot = SlotW'(i);
            found = 1'b1;
          end
        end
        if (!found) begin
          r.slot = rnd_slot;
          r.replaced = 1'b1;
        end
        tbl_frame[r.slot] = rq.frame;
        tbl_valid[r.slot] = 1'b1;
      end
      ACT_INV_ALL, ACT_INV_FRAME: begin
        for (int i = 0; i < Slots; i++) begin
          if (tbl_valid[i] && (rq.action == ACT_INV_ALL || tbl_frame[i] == rq.frame)) begin
            tbl_valid[i] = 1'b0;
            n++;
          end
        end
        r.cleared = CntW'(n);
      end
      default: ;
    endcase
    // The random slot counts down on every transfer and wraps above the wired slots.
    if (rnd_slot <= WiredSlots || rnd_slot > Slots - 1) rnd_slot = SlotW'(Slots - 1);
    else rnd_slot = rnd_slot - 1'b1;
    return r;
  endfunction

  // No idling at all while the progress count is in the quiet window.
  function automatic bit idle_now(int progress);
    return !(progress >= 700 && progress < 1000) && ($urandom_range(99) < 7);
  endfunction

  task automatic note_error(string what, int want_v, int got_v);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want_v, got_v);
  endtask

  task automatic queue_req(action_e act, logic [PageW-1:0] page, logic [FrameW-1:0] frame);
    tlb_req_t rq;
    rq.action = act;
    rq.page   = page;
    rq.frame  = frame;
    request_q.push_back(rq);
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        slot_result_q.push_back(apply_to_table({action_e'(req_ch.action), req_ch.virt_page,
                                                req_ch.phys_frame}));
        items_sent <= items_sent + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (request_q.size() != 0 && !idle_now(items_sent)) begin
          req_ch.valid      <= 1'b1;
          req_ch.action     <= request_q[0].action;
          req_ch.virt_page  <= request_q[0].page;
          req_ch.phys_frame <= request_q[0].frame;
          void'(request_q.pop_front());
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so that the block fills up and stalls its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if ((results_seen == 150 || results_seen == 1300) && hold_mark != results_seen) begin
      hold_cycles <= HoldLen;
      hold_mark   <= results_seen;
    end
  end

  // Response monitor.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen <= results_seen + 1;
        got_rsp = {rsp_ch.slot_written, rsp_ch.replaced_valid, rsp_ch.cleared_count};
        if (slot_result_q.size() == 0) begin
          note_error("unexpected result, slot", -1, got_rsp.slot);
        end else begin
          want_rsp = slot_result_q.pop_front();
          if (got_rsp.slot !== want_rsp.slot)
            note_error("slot_written", want_rsp.slot, got_rsp.slot);
          if (got_rsp.replaced !== want_rsp.replaced)
            note_error("replaced_valid", want_rsp.replaced, got_rsp.replaced);
          if (got_rsp.cleared !== want_rsp.cleared)
            note_error("cleared_count", want_rsp.cleared, got_rsp.cleared);
        end
      end
      rsp_ch.ready <= (hold_cycles == 0) && !idle_now(results_seen);
    end
  end

  // Watchdog: cycles without a transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic [FrameW-1:0] frame_pool [PoolSize];
    int                real_items;
    int                kind;
    int                len;
    logic [FrameW-1:0] fr;

    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_INSERT;
    req_ch.virt_page  = '0;
    req_ch.phys_frame = '0;
    rsp_ch.ready      = 1'b0;

    // Directed part: field extremes, frame hits and near misses, slot reuse,
    // clearing an empty table and the unused action code.
    queue_req(ACT_INSERT, '0, '0);
    queue_req(ACT_INSERT, '1, '1);
    queue_req(ACT_INSERT, 20'h5A5A5, 20'hA5A5A);
    queue_req(ACT_INSERT, 20'h12345, '1);
    queue_req(ACT_INV_FRAME, '0, '1);
    queue_req(ACT_INV_FRAME, '1, 20'h00001);
    queue_req(ACT_INSERT, 20'hABCDE, 20'h00001);
    queue_req(ACT_RSVD, '1, '1);
    queue_req(ACT_INV_FRAME, '0, '0);
    queue_req(ACT_INV_FRAME, '0, 20'h80000);
    queue_req(ACT_INV_ALL, '1, '1);
    queue_req(ACT_INV_ALL, '0, '0);
    queue_req(ACT_INV_FRAME, '0, '0);
    queue_req(ACT_RSVD, '0, '0);
    queue_req(ACT_INSERT, 20'h00001, 20'h7FFFF);
    real_items = request_q.size() - 2;

    frame_pool[0] = '0;
    frame_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) frame_pool[i] = FrameW'($urandom);

    // Random part: mostly insert runs that fill the table and force replacement,
    // invalidations by frames from a small pool so that they hit, and some noise.
    while (real_items < TotalItems) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        len = $urandom_range(1, 80);
        for (int i = 0; i < len; i++) begin
          fr = ($urandom_range(3) != 0) ? frame_pool[$urandom_range(PoolSize - 1)]
                                        : FrameW'($urandom);
          queue_req(ACT_INSERT, PageW'($urandom), fr);
        end
        real_items += len;
      end else if (kind < 78) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          fr = ($urandom_range(9) < 8) ? frame_pool[$urandom_range(PoolSize - 1)]
                                       : FrameW'($urandom);
          queue_req(ACT_INV_FRAME, PageW'($urandom), fr);
        end
        real_items += len;
      end else if (kind < 84) begin
        queue_req(ACT_INV_ALL, PageW'($urandom), FrameW'($urandom));
        real_items++;
      end else if (kind < 92) begin
        // Fill the whole table, replace a few entries, then clear everything.
        len = Slots + $urandom_range(0, 10);
        for (int i = 0; i < len; i++)
          queue_req(ACT_INSERT, PageW'($urandom), frame_pool[$urandom_range(PoolSize - 1)]);
        queue_req(ACT_INV_ALL, PageW'($urandom), FrameW'($urandom));
        real_items += len + 1;
      end else begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          queue_req(action_e'($urandom_range(3)), PageW'($urandom), FrameW'($urandom));
          if (request_q[$].action != ACT_RSVD) real_items++;
        end
      end
    end
    len = request_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_sent != len) @(posedge clk_i);
    while (slot_result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
